FILE: rtl/wpvc_pkg.sv
package wpvc_pkg;

	localparam int PathLengthDefault = 16;
	localparam int SlotW = 4;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_KP   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KI   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KD   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_VLIM = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ILIM = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DT   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_RATE = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_R2   = 3'd7;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic               action;
		logic [SlotW-1:0]   waypoint_slot;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] cmd_vx;
		logic signed [31:0] cmd_vy;
		logic signed [31:0] cmd_vz;
		logic               target_reached;
		logic [SlotW-1:0]   active_target;
	} out_item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [31:0]        data;
	} cfg_req_t;

	// lane settings, shared by all three lanes
	typedef struct packed {
		logic [23:0] kp;
		logic [23:0] ki;
		logic [23:0] kd;
		logic [30:0] vlim;
		logic [30:0] ilim;
		logic [15:0] dt;
		logic [15:0] rate;
	} gains_t;

	// lane step control
	typedef struct packed {
		logic start;
		logic armed;
		logic clear_int;
	} lane_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		else if (v < -64'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

endpackage

FILE: rtl/waypoint_pid_velocity_controller_core.sv
// Three-axis waypoint PID velocity controller. A load request writes one waypoint slot
// (slots at or above PATH_LENGTH are dropped) and gives no result. A tick request
// reads the current waypoint and runs the three axes in parallel lanes: error and
// integral, the three gain products, then the sum and velocity clamp, and a merge of
// the squared errors decides arrival. A tick's result follows the waypoint RAM read
// and the four lane stages; one request is in flight at a time. The table has valid
// bits, so no clear pass.
module waypoint_pid_velocity_controller_core #(
	parameter int PathLength = wpvc_pkg::PathLengthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wpvc_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wpvc_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  wpvc_pkg::cfg_req_t   cfg_data
);
	localparam int PtrW = (PathLength > 1) ? $clog2(PathLength) : 1;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_LANE = 3'd2,
		ST_DONE = 3'd3;

	wpvc_pkg::gains_t gains_q;
	logic [31:0]      r2_q;
	logic [2:0]       state_q;
	logic [1:0]       cnt_q;
	logic [PtrW-1:0]  ptr_q;
	logic             armed_q;
	logic [PathLength-1:0] vld_q;
	logic             rvld_s1;
	logic signed [31:0] mx_q, my_q, mz_q;
	logic [95:0]      rdata;
	logic signed [31:0] tx, ty, tz;
	logic signed [31:0] vx, vy, vz;
	logic [63:0]      sqx, sqy, sqz;
	logic [65:0]      dist_sq;
	logic             reached;
	logic             in_acc, ld_ok, start;
	logic [PtrW-1:0]  wslot, ptr_next;
	wpvc_pkg::lane_ctl_t ctl;

	assign in_stall  = (state_q != ST_IDLE) || out_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign wslot     = PtrW'(in_data.waypoint_slot);
	assign ld_ok     = in_acc && in_data.action == wpvc_pkg::ACT_LOAD
		&& 32'(in_data.waypoint_slot) < 32'(PathLength);
	assign start     = state_q == ST_READ;
	assign {tx, ty, tz} = rvld_s1 ? rdata : 96'd0;
	assign dist_sq   = 66'(sqx) + 66'(sqy) + 66'(sqz);
	assign reached   = dist_sq < {18'd0, r2_q, 16'd0};
	assign ptr_next  = (32'(ptr_q) == PathLength - 1) ? '0 : ptr_q + 1'b1;
	assign ctl = '{start: start, armed: armed_q,
		clear_int: state_q == ST_DONE && reached};

	wpvc_ram #(.Width(96), .Depth(PathLength)) u_table (
		.clk(clk), .we(ld_ok), .waddr(wslot),
		.wdata({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
		.raddr(ptr_q), .rdata(rdata));

	wpvc_lane u_lx (.clk(clk), .arst_n(arst_n), .ctl(ctl), .gains(gains_q),
		.target(tx), .measured(mx_q), .velocity(vx), .err_sq(sqx));
	wpvc_lane u_ly (.clk(clk), .arst_n(arst_n), .ctl(ctl), .gains(gains_q),
		.target(ty), .measured(my_q), .velocity(vy), .err_sq(sqy));
	wpvc_lane u_lz (.clk(clk), .arst_n(arst_n), .ctl(ctl), .gains(gains_q),
		.target(tz), .measured(mz_q), .velocity(vz), .err_sq(sqz));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '{kp: 24'd229376, ki: 24'd6554, kd: 24'd65536,
				vlim: 31'd262144, ilim: 31'd2621440, dt: 16'd655, rate: 16'd100};
			r2_q      <= 32'd2621;
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			armed_q   <= 1'b0;
			vld_q     <= '0;
			rvld_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					wpvc_pkg::REG_KP:   gains_q.kp   <= cfg_data.data[23:0];
					wpvc_pkg::REG_KI:   gains_q.ki   <= cfg_data.data[23:0];
					wpvc_pkg::REG_KD:   gains_q.kd   <= cfg_data.data[23:0];
					wpvc_pkg::REG_VLIM: gains_q.vlim <= cfg_data.data[30:0];
					wpvc_pkg::REG_ILIM: gains_q.ilim <= cfg_data.data[30:0];
					wpvc_pkg::REG_DT:   gains_q.dt   <= cfg_data.data[15:0];
					wpvc_pkg::REG_RATE: gains_q.rate <= cfg_data.data[15:0];
					wpvc_pkg::REG_R2:   r2_q         <= cfg_data.data;
					default: ;
				endcase
			end
			if (ld_ok) vld_q[wslot] <= 1'b1;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.action == wpvc_pkg::ACT_TICK) begin
						state_q <= ST_READ;
						rvld_s1 <= vld_q[ptr_q];
					end
				end
				ST_READ: begin
					state_q <= ST_LANE;
					cnt_q   <= '0;
				end
				ST_LANE: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q   <= ST_IDLE;
					out_valid <= 1'b1;
					armed_q   <= 1'b1;
					if (reached) ptr_q <= ptr_next;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mx_q <= in_data.coord_x;
			my_q <= in_data.coord_y;
			mz_q <= in_data.coord_z;
		end
		if (state_q == ST_DONE) begin
			out_data.cmd_vx         <= vx;
			out_data.cmd_vy         <= vy;
			out_data.cmd_vz         <= vz;
			out_data.target_reached <= reached;
			out_data.active_target  <= wpvc_pkg::SlotW'(ptr_q);
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_acc) else $error("request accepted while busy");
	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> out_valid) else $error("tick lost its result");
	a_ptr_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q != $past(ptr_q) |-> $past(state_q) == ST_DONE)
		else $error("pointer moved outside a tick");
endmodule

FILE: rtl/wpvc_ram.sv
module wpvc_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/wpvc_lane.sv
// One axis: error, integral, derivative and PID sum over four stages.
module wpvc_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wpvc_pkg::lane_ctl_t    ctl,
	input  wpvc_pkg::gains_t       gains,
	input  logic signed [31:0]     target,
	input  logic signed [31:0]     measured,
	output logic signed [31:0]     velocity,
	output logic [63:0]            err_sq
);
	logic signed [31:0] integ_q, prev_q;
	logic signed [31:0] e_s1;
	logic signed [31:0] integ_s2, deriv_s2;
	logic signed [56:0] pe_s2;
	logic signed [56:0] pi_s3, pd_s3, pe_s3;
	logic [1:0]         st_q;
	logic signed [32:0] diff;
	logic signed [48:0] e_dt;
	logic signed [33:0] isum;
	logic signed [33:0] ddiff;
	logic signed [50:0] dmul;
	logic signed [58:0] acc;
	logic signed [42:0] accs;
	logic [31:0]        mag;

	assign diff  = 33'(target) - 33'(measured);
	assign e_dt  = 49'(e_s1) * $signed({1'b0, gains.dt});
	assign isum  = 34'(integ_q) + 34'(e_dt >>> 16);
	assign ddiff = 34'(e_s1) - 34'(prev_q);
	assign dmul  = 51'(ddiff) * $signed({1'b0, gains.rate});
	assign acc   = 59'(pe_s3) + 59'(pi_s3) + 59'(pd_s3);
	assign accs  = 43'(acc >>> 16);
	assign mag   = e_s1[31] ? 32'(-33'(e_s1)) : e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			st_q    <= '0;
		end else begin
			if (ctl.start) st_q <= 2'd1;
			else if (st_q != 2'd0) st_q <= st_q + 2'd1;
			if (st_q == 2'd1) begin
				if (isum > $signed({3'b0, gains.ilim})) integ_q <= $signed({1'b0, gains.ilim});
				else if (isum < -$signed({3'b0, gains.ilim}))
					integ_q <= 32'(-$signed({1'b0, gains.ilim}));
				else integ_q <= isum[31:0];
				prev_q <= e_s1;
			end
			if (ctl.clear_int) integ_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) e_s1 <= wpvc_pkg::sat32(64'(diff));
		if (st_q == 2'd1) begin
			if (isum > $signed({3'b0, gains.ilim})) integ_s2 <= $signed({1'b0, gains.ilim});
			else if (isum < -$signed({3'b0, gains.ilim}))
				integ_s2 <= 32'(-$signed({1'b0, gains.ilim}));
			else integ_s2 <= isum[31:0];
			deriv_s2 <= ctl.armed ? wpvc_pkg::sat32(64'(dmul)) : '0;
			pe_s2    <= 57'(e_s1) * $signed({1'b0, gains.kp});
			err_sq   <= 64'(mag) * 64'(mag);
		end
		if (st_q == 2'd2) begin
			pe_s3 <= pe_s2;
			pi_s3 <= 57'(integ_s2) * $signed({1'b0, gains.ki});
			pd_s3 <= 57'(deriv_s2) * $signed({1'b0, gains.kd});
		end
		if (st_q == 2'd3) begin
			if (accs > $signed({12'b0, gains.vlim})) velocity <= $signed({1'b0, gains.vlim});
			else if (accs < -$signed({12'b0, gains.vlim}))
				velocity <= 32'(-$signed({1'b0, gains.vlim}));
			else velocity <= accs[31:0];
		end
	end
endmodule
